// ===== hw/rtl/min_heap_priority_queue_defines.svh =====
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hpq_pkg.sv =====
package hpq_pkg;

  localparam int OCC_W = 11;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NEG   = 2'd3
  } status_t;

  typedef struct packed {
    logic               action;
    logic signed [7:0]  item_symbol;
    logic        [31:0] item_key;
  } in_word_t;

  typedef struct packed {
    logic [6:0]       out_symbol;
    logic [31:0]      out_key;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  // One heap slot as stored in the entry RAM.
  typedef struct packed {
    logic [6:0]  sym;
    logic [31:0] key;
  } entry_t;

endpackage

// ===== hw/rtl/hpq_heap_ram.sv =====
module hpq_heap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  hpq_pkg::entry_t wdata,
  input  logic [AW-1:0]  raddr,
  output hpq_pkg::entry_t rdata
);

  hpq_pkg::entry_t mem [DEPTH];
  hpq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/min_heap_priority_queue.sv =====
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+----------------------------------
// input    | start, busy, in_data (in_word_t)   | word taken when start && !busy
// result   | out_valid, out_data (out_word_t)   | one-cycle strobe, cannot be stalled
//
// A rejected, full or empty operation answers in the cycle after it is taken.
// An insert reads and compares one parent per level, moving each larger parent down.
// A remove reads the root and then the last entry, then per level reads the children
// and compares; the RAM has separate write and read ports and a registered read.
// Synchronous active-low reset empties the heap; the RAM itself is never cleared.
// busy is high while an operation walks the heap; the result side has no stall.
module min_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hpq_pkg::in_word_t  in_data,
  output logic               out_valid,
  output hpq_pkg::out_word_t out_data
);

  `include "min_heap_priority_queue_defines.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_DN_LAST = 9'b000001000,
    S_DN_LOAD = 9'b000010000,
    S_DN_RDL  = 9'b000100000,
    S_DN_RDR  = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  hpq_pkg::entry_t    mov_r, mov_nxt;
  hpq_pkg::entry_t    child_r, child_nxt;
  hpq_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  hpq_pkg::entry_t    mem_wdata;
  logic [AW-1:0]      mem_raddr;
  hpq_pkg::entry_t    mem_rdata;

  logic [CW:0]        lc_w, rc_w, cnt_w;
  logic [CW-1:0]      parent_pos;
  logic               take_right;
  hpq_pkg::entry_t    pick;
  logic [CW:0]        pick_pos;
  logic [CW+hpq_pkg::OCC_W-1:0] occ_ext;

  hpq_heap_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign lc_w       = {pos_r, 1'b0};
  assign rc_w       = {pos_r, 1'b1};
  assign cnt_w      = {1'b0, count_r};
  assign parent_pos = pos_r >> 1;
  // Ties between the children go to the right one.
  assign take_right = (rc_w <= cnt_w) && !(child_r.key < mem_rdata.key);
  assign pick       = take_right ? mem_rdata : child_r;
  assign pick_pos   = take_right ? rc_w : lc_w;
  assign occ_ext    = {{hpq_pkg::OCC_W{1'b0}}, count_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    mov_nxt       = mov_r;
    child_nxt     = child_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(pos_r - ONE_C);
    mem_wdata     = mov_r;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt.out_symbol = '0;
          out_nxt.out_key    = '0;
          out_nxt.status     = hpq_pkg::ST_OK;
          out_nxt.occupancy  = occ_ext[hpq_pkg::OCC_W-1:0];
          if (in_data.action == hpq_pkg::ACT_INSERT) begin
            if (in_data.item_symbol[7]) begin
              out_nxt.status = hpq_pkg::ST_NEG;
              out_valid_nxt  = 1'b1;
            end else if (count_r >= CAP_C) begin
              out_nxt.status = hpq_pkg::ST_FULL;
              out_valid_nxt  = 1'b1;
            end else begin
              count_nxt   = count_r + ONE_C;
              pos_nxt     = count_r + ONE_C;
              mov_nxt.sym = in_data.item_symbol[6:0];
              mov_nxt.key = in_data.item_key;
              state_nxt   = (count_r == '0) ? S_FIN : S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              out_nxt.status = hpq_pkg::ST_EMPTY;
              out_valid_nxt  = 1'b1;
            end else begin
              mem_raddr = '0;
              state_nxt = S_DN_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        mem_raddr = AW'(parent_pos - ONE_C);
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (mem_rdata.key > mov_r.key) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_nxt   = parent_pos;
          state_nxt = (parent_pos == ONE_C) ? S_FIN : S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_LAST: begin
        // The root arrives now; fetch the last entry to refill it.
        out_nxt.out_symbol = mem_rdata.sym;
        out_nxt.out_key    = mem_rdata.key;
        mem_raddr          = AW'(count_r - ONE_C);
        count_nxt          = count_r - ONE_C;
        state_nxt          = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        mov_nxt   = mem_rdata;
        pos_nxt   = ONE_C;
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (lc_w > cnt_w) begin
          state_nxt = S_FIN;
        end else begin
          mem_raddr = AW'(lc_w - (CW+1)'(1));
          state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        child_nxt = mem_rdata;
        mem_raddr = AW'(rc_w - (CW+1)'(1));
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (mov_r.key <= pick.key) begin
          state_nxt = S_FIN;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = pick;
          pos_nxt   = CW'(pick_pos);
          state_nxt = S_DN_RDL;
        end
      end
      S_FIN: begin
        mem_we            = 1'b1;
        out_nxt.status    = hpq_pkg::ST_OK;
        out_nxt.occupancy = occ_ext[hpq_pkg::OCC_W-1:0];
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    mov_r   <= mov_nxt;
    child_r <= child_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_C, "entry count above capacity")
  `HPQ_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE,
                  "result strobe while a walk is in progress")
  `HPQ_ASSERT_NEXT(a_count_hold, state_r != S_IDLE && state_r != S_DN_LAST,
                   $stable(count_r), "entry count moved during a walk")
  `HPQ_ASSERT_NEXT(a_neg_reject,
                   start && !busy && in_data.action == hpq_pkg::ACT_INSERT &&
                   in_data.item_symbol[7],
                   out_valid && out_data.status == hpq_pkg::ST_NEG,
                   "negative symbol not rejected at once")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  hpq_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  hpq_pkg::out_word_t out_data;

  // Shadow copy of the heap, updated at the edge where each word is taken.
  logic [6:0]  shadow_sym [1:CAP];
  logic [31:0] shadow_key [1:CAP];
  int          shadow_count = 0;

  hpq_pkg::out_word_t heap_answers[$];
  int                 fail_count = 0;
  int                 no_gap_left = 0;

  min_heap_priority_queue #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic swap_slots(input int a, input int b);
    logic [6:0]  ts;
    logic [31:0] tk;
    ts = shadow_sym[a];
    tk = shadow_key[a];
    shadow_sym[a] = shadow_sym[b];
    shadow_key[a] = shadow_key[b];
    shadow_sym[b] = ts;
    shadow_key[b] = tk;
  endtask

  task automatic apply_heap_op(input hpq_pkg::in_word_t w, output hpq_pkg::out_word_t r);
    int pos;
    int lc;
    int rc;
    int pick;
    r = '0;
    r.status = hpq_pkg::ST_OK;
    if (w.action == hpq_pkg::ACT_INSERT) begin
      // A negative symbol is rejected even when the heap is also full.
      if (w.item_symbol[7]) begin
        r.status = hpq_pkg::ST_NEG;
      end else if (shadow_count >= CAP) begin
        r.status = hpq_pkg::ST_FULL;
      end else begin
        shadow_count++;
        pos = shadow_count;
        shadow_sym[pos] = w.item_symbol[6:0];
        shadow_key[pos] = w.item_key;
        while (pos > 1) begin
          if (shadow_key[pos / 2] > shadow_key[pos]) begin
            swap_slots(pos / 2, pos);
            pos = pos / 2;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = hpq_pkg::ST_EMPTY;
      end else begin
        r.out_symbol = shadow_sym[1];
        r.out_key = shadow_key[1];
        if (shadow_count > 1) begin
          shadow_sym[1] = shadow_sym[shadow_count];
          shadow_key[1] = shadow_key[shadow_count];
        end
        shadow_count--;
        pos = 1;
        while (2 * pos <= shadow_count) begin
          lc = 2 * pos;
          rc = lc + 1;
          // Equal child keys send the walk to the right child.
          if (rc > shadow_count || shadow_key[lc] < shadow_key[rc]) begin
            pick = lc;
          end else begin
            pick = rc;
          end
          if (shadow_key[pos] <= shadow_key[pick]) begin
            break;
          end
          swap_slots(pos, pick);
          pos = pick;
        end
      end
    end
    r.occupancy = hpq_pkg::OCC_W'(shadow_count);
  endtask

  function automatic int next_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      no_gap_left = $urandom_range(10, 40);
      return 0;
    end else if (r < 35) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_key();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    end else if (r < 55) begin
      // A narrow range gives many equal keys.
      return 32'($urandom_range(0, 31));
    end
    return $urandom();
  endfunction

  function automatic hpq_pkg::in_word_t junk_word();
    hpq_pkg::in_word_t w;
    w.action = 1'($urandom_range(1));
    w.item_symbol = 8'($urandom_range(255));
    w.item_key = $urandom();
    return w;
  endfunction

  function automatic hpq_pkg::in_word_t insert_word(input logic [7:0] sym,
                                                    input logic [31:0] key);
    hpq_pkg::in_word_t w;
    w.action = hpq_pkg::ACT_INSERT;
    w.item_symbol = sym;
    w.item_key = key;
    return w;
  endfunction

  function automatic hpq_pkg::in_word_t remove_word();
    hpq_pkg::in_word_t w;
    w = junk_word();
    w.action = hpq_pkg::ACT_REMOVE;
    return w;
  endfunction

  // Holds start high until the word is taken, then records its answer.
  task automatic send_word(input hpq_pkg::in_word_t w);
    int                 gap;
    hpq_pkg::out_word_t ans;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= junk_word();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_heap_op(w, ans);
    heap_answers.push_back(ans);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    hpq_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (heap_answers.size() == 0) begin
        $display("%0t: result word with none pending, expected nothing, actual %h",
                 $time, out_data);
        fail_count++;
      end else begin
        want = heap_answers.pop_front();
        report_field("out_symbol", 32'(want.out_symbol), 32'(out_data.out_symbol));
        report_field("out_key", want.out_key, out_data.out_key);
        report_field("status", 32'(want.status), 32'(out_data.status));
        report_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
      end
    end
  end

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_empty_and_single();
    send_word(remove_word());
    send_word(insert_word(8'd127, 32'hFFFF_FFFF));
    send_word(remove_word());
    send_word(remove_word());
  endtask

  task automatic test_rejects();
    send_word(insert_word(8'h80, 32'h0));
    send_word(insert_word(8'hFF, 32'hFFFF_FFFF));
    send_word(insert_word(8'd0, 32'h0));
    send_word(remove_word());
  endtask

  task automatic test_ties_and_extremes();
    send_word(insert_word(8'd10, 32'h100));
    send_word(insert_word(8'd11, 32'h100));
    send_word(insert_word(8'd12, 32'h100));
    send_word(insert_word(8'd13, 32'h100));
    send_word(insert_word(8'd0, 32'h0));
    send_word(insert_word(8'd127, 32'hFFFF_FFFF));
    send_word(insert_word(8'd14, 32'h100));
    repeat (8) send_word(remove_word());
  endtask

  // Mostly good inserts with some removes and rejects, until the heap is full.
  task automatic test_fill_to_full();
    int r;
    while (shadow_count < CAP) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_word(insert_word(8'($urandom_range(128, 255)), random_key()));
      end else if (r < 97) begin
        send_word(insert_word(8'($urandom_range(0, 127)), random_key()));
      end else begin
        send_word(remove_word());
      end
    end
  endtask

  task automatic test_churn_at_full();
    int r;
    repeat (40) begin
      r = $urandom_range(99);
      if (shadow_count == CAP) begin
        if (r < 15) begin
          send_word(insert_word(8'($urandom_range(128, 255)), random_key()));
        end else if (r < 60) begin
          send_word(insert_word(8'($urandom_range(0, 127)), random_key()));
        end else begin
          send_word(remove_word());
        end
      end else begin
        if (r < 10) begin
          send_word(insert_word(8'($urandom_range(128, 255)), random_key()));
        end else if (r < 70) begin
          send_word(insert_word(8'($urandom_range(0, 127)), random_key()));
        end else begin
          send_word(remove_word());
        end
      end
    end
  endtask

  initial begin
    do_reset();
    test_empty_and_single();
    test_rejects();
    test_ties_and_extremes();
    test_fill_to_full();
    test_churn_at_full();
    @(negedge clk);
    start <= 1'b0;
    while (heap_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
